// ===== rtl/assert_macros.svh =====
// Assertion helpers, clocked on i_clk
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only out of reset
`define SGCF_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("sgcf assertion failed");

// checked at every edge, reset included
`define SGCF_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) (prop)) \
        else $error("sgcf assertion failed");

`endif

// ===== rtl/sgcf_pkg.sv =====
`timescale 1ns / 1ps

package sgcf_pkg;

    localparam int NUM_FILTERS = 3;
    localparam int NUM_SLOTS   = 3;
    localparam int MAX_BINS    = 16384;

    localparam int BIN_W   = 14;
    localparam int AZ_W    = 14;
    localparam int SMP_W   = 16;
    localparam int CFG_W   = 64;
    localparam int CFG_IDX_W = 3;
    localparam int V_W     = 33;

    localparam logic [BIN_W-1:0] BIN_LAST = BIN_W'(MAX_BINS - 1);

    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIN0   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SHP0   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WIN1   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SHP1   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_WIN2   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SHP2   = 3'd6;

    typedef struct packed {
        logic             valid;
        logic [BIN_W-1:0] bin_end;
        logic [BIN_W-1:0] bin_start;
        logic [AZ_W-1:0]  az_max;
        logic [AZ_W-1:0]  az_min;
    } t_window;

    typedef struct packed {
        logic signed [SMP_W-1:0] cmax;
        logic signed [SMP_W-1:0] cmin;
        logic signed [SMP_W-1:0] offset;
        logic signed [SMP_W-1:0] gain;
    } t_shaping;

    typedef struct packed {
        logic ld_c;
        logic ld_d;
    } t_pipe_ld;

endpackage

// ===== rtl/sgcf_match.sv =====
`timescale 1ns / 1ps

module sgcf_match import sgcf_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_ld,
    input  logic                    i_enable,
    input  t_window                 i_win [NUM_SLOTS],
    input  t_shaping                i_shp [NUM_SLOTS],
    input  logic signed [SMP_W-1:0] i_sample,
    input  logic [AZ_W-1:0]         i_az,
    input  logic [BIN_W-1:0]        i_bin,
    output logic signed [SMP_W-1:0] o_sample,
    output logic                    o_applied,
    output t_shaping                o_shp
);

    logic                    n_applied;
    t_shaping                n_shp;
    logic signed [SMP_W-1:0] r_sample;
    logic                    r_applied;
    t_shaping                r_shp;

    // highest matching sector wins
    always_comb begin
        n_applied = 1'b0;
        n_shp     = i_shp[0];
        for (int k = 0; k < NUM_FILTERS; k++) begin
            if (i_enable && i_win[k].valid &&
                i_az >= i_win[k].az_min && i_az <= i_win[k].az_max &&
                i_bin >= i_win[k].bin_start && i_bin < i_win[k].bin_end) begin
                n_applied = 1'b1;
                n_shp     = i_shp[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ld) begin
            r_sample  <= i_sample;
            r_applied <= n_applied;
            r_shp     <= n_shp;
        end
    end

    assign o_sample  = r_sample;
    assign o_applied = r_applied;
    assign o_shp     = r_shp;

endmodule

// ===== rtl/sgcf_shape.sv =====
`timescale 1ns / 1ps

module sgcf_shape import sgcf_pkg::*; (
    input  logic                    i_clk,
    input  t_pipe_ld                i_ctl,
    input  logic signed [SMP_W-1:0] i_sample,
    input  logic                    i_applied,
    input  t_shaping                i_shp,
    output logic signed [SMP_W-1:0] o_sample,
    output logic                    o_applied
);

    logic signed [2*SMP_W-1:0] prod;
    logic signed [V_W-1:0]     n_v;
    logic signed [V_W-1:0]     r_v;
    logic                      r_c_applied;
    logic signed [SMP_W-1:0]   r_c_sample;
    logic signed [SMP_W-1:0]   r_c_cmin;
    logic signed [SMP_W-1:0]   r_c_cmax;

    logic signed [V_W-1:0]     lim_min;
    logic signed [V_W-1:0]     lim_max;
    logic                      round_up;
    logic [SMP_W-1:0]          rounded;
    logic signed [SMP_W-1:0]   n_out;
    logic signed [SMP_W-1:0]   r_d_sample;
    logic                      r_d_applied;

    // v = sample * gain + offset * 256, Q.8
    assign prod = (2*SMP_W)'(i_sample) * (2*SMP_W)'(i_shp.gain);
    assign n_v  = $signed({prod[2*SMP_W-1], prod})
                + $signed({{(V_W-SMP_W-8){i_shp.offset[SMP_W-1]}}, i_shp.offset, 8'h00});

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld_c) begin
            r_v         <= n_v;
            r_c_applied <= i_applied;
            r_c_sample  <= i_sample;
            r_c_cmin    <= i_shp.cmin;
            r_c_cmax    <= i_shp.cmax;
        end
    end

    assign lim_min  = $signed({{(V_W-SMP_W-8){r_c_cmin[SMP_W-1]}}, r_c_cmin, 8'h00});
    assign lim_max  = $signed({{(V_W-SMP_W-8){r_c_cmax[SMP_W-1]}}, r_c_cmax, 8'h00});
    // round half to even
    assign round_up = (r_v[7:0] > 8'h80) || ((r_v[7:0] == 8'h80) && r_v[8]);
    assign rounded  = r_v[SMP_W+7:8] + SMP_W'(round_up);

    always_comb begin
        if (!r_c_applied) begin
            n_out = r_c_sample;
        end else if (r_v < lim_min) begin
            n_out = (r_c_cmin > r_c_cmax) ? r_c_cmax : r_c_cmin;
        end else if (r_v > lim_max) begin
            n_out = r_c_cmax;
        end else begin
            n_out = $signed(rounded);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld_d) begin
            r_d_sample  <= n_out;
            r_d_applied <= r_c_applied;
        end
    end

    assign o_sample  = r_d_sample;
    assign o_applied = r_d_applied;

endmodule

// ===== rtl/sector_gain_clamp_filter.sv =====
`timescale 1ns / 1ps
// Sector gain/clamp filter for radar video.
// Input request: i_sample_in, i_azimuth_code, i_sweep_start with i_valid;
// taken when i_valid is high and o_stall is low. Output request:
// o_sample_out, o_filter_applied with o_valid; taken when i_stall is low.
// Configuration: i_cfg_we writes i_cfg_data to register i_cfg_idx
// (0 enable, then window/shaping per sector); write only while idle.
// o_valid follows the accepting edge through the pipeline registers; one
// request per cycle sustained while i_stall is low, in a four-register pipeline
// (input, sector select, 16x16 multiply, clamp/round) with one multiplier.
// The range-bin counter advances on each accepted request, restarts on
// sweep start and saturates at the last bin.
// Synchronous reset clears the configuration, the bin counter and the
// pipeline valid flags; o_stall is high during reset. When the receiver
// stalls, the output holds and earlier stages keep filling bubbles;
// o_stall rises once the pipeline is full.
module sector_gain_clamp_filter import sgcf_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic signed [SMP_W-1:0] i_sample_in,
    input  logic [AZ_W-1:0]         i_azimuth_code,
    input  logic                    i_sweep_start,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic signed [SMP_W-1:0] o_sample_out,
    output logic                    o_filter_applied,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [CFG_W-1:0]        i_cfg_data
);

    logic                    r_enable;
    t_window                 r_win [NUM_SLOTS];
    t_shaping                r_shp [NUM_SLOTS];
    logic [BIN_W-1:0]        r_bin_cnt;

    logic                    r_a_valid;
    logic                    r_b_valid;
    logic                    r_c_valid;
    logic                    r_d_valid;
    logic signed [SMP_W-1:0] r_a_sample;
    logic [AZ_W-1:0]         r_a_az;
    logic [BIN_W-1:0]        r_a_bin;

    logic                    adv_a;
    logic                    adv_b;
    logic                    adv_c;
    logic                    adv_d;
    logic                    accept;
    logic [BIN_W-1:0]        bin;
    logic [BIN_W-1:0]        n_bin_cnt;
    t_pipe_ld                shp_ctl;

    logic signed [SMP_W-1:0] b_sample;
    logic                    b_applied;
    t_shaping                b_shp;

    assign adv_d   = !r_d_valid || !i_stall;
    assign adv_c   = !r_c_valid || adv_d;
    assign adv_b   = !r_b_valid || adv_c;
    assign adv_a   = !r_a_valid || adv_b;
    assign o_stall = !i_rst_n || !adv_a;
    assign accept  = i_valid && !o_stall;

    assign bin       = i_sweep_start ? '0 : r_bin_cnt;
    assign n_bin_cnt = (bin == BIN_LAST) ? bin : bin + BIN_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable  <= 1'b0;
            r_bin_cnt <= '0;
            for (int k = 0; k < NUM_SLOTS; k++) begin
                r_win[k] <= '0;
                r_shp[k] <= '0;
            end
        end else begin
            if (accept) begin
                r_bin_cnt <= n_bin_cnt;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_ENABLE: r_enable <= i_cfg_data[0];
                    CFG_WIN0:   r_win[0] <= t_window'(i_cfg_data[$bits(t_window)-1:0]);
                    CFG_SHP0:   r_shp[0] <= t_shaping'(i_cfg_data);
                    CFG_WIN1:   r_win[1] <= t_window'(i_cfg_data[$bits(t_window)-1:0]);
                    CFG_SHP1:   r_shp[1] <= t_shaping'(i_cfg_data);
                    CFG_WIN2:   r_win[2] <= t_window'(i_cfg_data[$bits(t_window)-1:0]);
                    CFG_SHP2:   r_shp[2] <= t_shaping'(i_cfg_data);
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
        end else begin
            if (adv_a) r_a_valid <= accept;
            if (adv_b) r_b_valid <= r_a_valid;
            if (adv_c) r_c_valid <= r_b_valid;
            if (adv_d) r_d_valid <= r_c_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_a) begin
            r_a_sample <= i_sample_in;
            r_a_az     <= i_azimuth_code;
            r_a_bin    <= bin;
        end
    end

    sgcf_match u_match (
        .i_clk     (i_clk),
        .i_ld      (adv_b),
        .i_enable  (r_enable),
        .i_win     (r_win),
        .i_shp     (r_shp),
        .i_sample  (r_a_sample),
        .i_az      (r_a_az),
        .i_bin     (r_a_bin),
        .o_sample  (b_sample),
        .o_applied (b_applied),
        .o_shp     (b_shp)
    );

    assign shp_ctl.ld_c = adv_c;
    assign shp_ctl.ld_d = adv_d;

    sgcf_shape u_shape (
        .i_clk     (i_clk),
        .i_ctl     (shp_ctl),
        .i_sample  (b_sample),
        .i_applied (b_applied),
        .i_shp     (b_shp),
        .o_sample  (o_sample_out),
        .o_applied (o_filter_applied)
    );

    assign o_valid = r_d_valid;

endmodule

// ===== rtl/sgcf_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sgcf_checker import sgcf_pkg::*; (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    o_stall,
    input logic                    o_valid,
    input logic                    i_stall,
    input logic signed [SMP_W-1:0] o_sample_out,
    input logic                    o_filter_applied
);

    logic [SMP_W:0] out_word;

    assign out_word = {o_filter_applied, o_sample_out};

    `SGCF_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> !o_valid)
    `SGCF_ASSERT_ALWAYS(a_stall_in_reset, !i_rst_n |-> o_stall)
    `SGCF_ASSERT(a_free_output_no_stall, !(o_valid && i_stall) |-> !o_stall)
    `SGCF_ASSERT(a_output_held, o_valid && i_stall |=> o_valid && $stable(out_word))

endmodule

bind sector_gain_clamp_filter sgcf_checker u_sgcf_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_stall          (o_stall),
    .o_valid          (o_valid),
    .i_stall          (i_stall),
    .o_sample_out     (o_sample_out),
    .o_filter_applied (o_filter_applied)
);
